// ===== hw/rtl/wut_pkg.sv =====
// ----------------------------------------------------------------------------
// wut_pkg
// Shared types and constants of the word and URI tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wut_pkg;

  localparam int CHAR_W    = 21;
  localparam int LEN_W     = 6;
  localparam int CMD_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_TAB    = 21'd9;
  localparam logic [CHAR_W-1:0] CH_CR     = 21'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 21'd32;
  localparam logic [CHAR_W-1:0] CH_BANG   = 21'd33;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 21'd34;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 21'd39;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 21'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 21'd45;
  localparam logic [CHAR_W-1:0] CH_DOT    = 21'd46;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 21'd47;
  localparam logic [CHAR_W-1:0] CH_DIG_0  = 21'd48;
  localparam logic [CHAR_W-1:0] CH_DIG_9  = 21'd57;
  localparam logic [CHAR_W-1:0] CH_COLON  = 21'd58;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 21'd65;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 21'd90;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 21'd97;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 21'd122;
  localparam logic [CHAR_W-1:0] CH_PIPE   = 21'd124;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 21'd126;
  localparam logic [CHAR_W-1:0] CH_DEL    = 21'd127;
  localparam logic [CHAR_W-1:0] CH_US     = 21'd31;

  typedef enum logic [2:0] {
    ST_GROUND      = 3'd0,
    ST_WORD        = 3'd1,
    ST_QUOTED      = 3'd2,
    ST_URI_MAYBE   = 3'd3,
    ST_END_SCHEME  = 3'd4,
    ST_POST_SCHEME = 3'd5,
    ST_AUTH        = 3'd6,
    ST_PATH        = 3'd7
  } state_t;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_PEND = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // one report request: kind, word length, overflow and first character
  // (the offending code for an error)
  typedef struct packed {
    kind_t             kind;
    logic [LEN_W-1:0]  len;
    logic              ovf;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pending;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/word_and_uri_tokenizer_core.sv =====
// ----------------------------------------------------------------------------
// word_and_uri_tokenizer_core
// Character-stream tokenizer for words, quoted words and URIs.
// ----------------------------------------------------------------------------
// Input stream: one code point per request in in_tdata; in_tlast set flushes
// the pending word and returns the tokenizer to ground (the code is ignored).
// Output stream: one request per character of a reported word, out_tlast on
// the final one; out_tuser gives the kind (completed word, pending word at end
// of input, no-transition error).
// A character that neither reports nor writes the buffer is never held.
// A report is read out one character per cycle while out_tready is high,
// through the queue, a request register and the output register, its first
// character from the request and the rest from the word buffer RAM; an error
// or empty report is one result. The queue holds two reports, so the input
// side goes on during readout; a buffer write waits until the queue is empty.
// Reset (synchronous, rst_n low) returns to ground with an empty word and
// drops queued reports; the buffer RAM is not cleared.
// When the receiver holds out_tready low the output register holds its
// request, the reader stalls, and the input side stalls once the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_and_uri_tokenizer_core #(
  parameter int MAX_WORD_CHARS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [20:0] char_code, [23:21] zero
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] out_char, [21] empty_res,
                                  // [22] truncated, [23] zero
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last
);
  import wut_pkg::*;

  localparam int AW = $clog2(MAX_WORD_CHARS);

  fifo_stat_t        fifo_stat;
  cmd_t              push_cmd, head_cmd;
  logic              push, pop;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wdata, rdata;
  kind_t             out_kind;
  logic [CHAR_W-1:0] out_char;
  logic              out_empty, out_trunc;

  wut_front #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .char_code    (in_tdata[CHAR_W-1:0]),
    .end_of_input (in_tlast),
    .fifo_stat    (fifo_stat),
    .push         (push),
    .push_cmd     (push_cmd),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata)
  );

  wut_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (fifo_stat)
  );

  wut_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_WORD_CHARS)
  ) u_buf (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  wut_back #(
    .MAX_WORD_CHARS (MAX_WORD_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fifo_stat (fifo_stat),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .re        (re),
    .raddr     (raddr),
    .rdata     (rdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_kind),
    .out_char  (out_char),
    .out_last  (out_tlast),
    .out_empty (out_empty),
    .out_trunc (out_trunc)
  );

  assign out_tdata = {1'b0, out_trunc, out_empty, out_char};
  assign out_tuser = out_kind;

endmodule

// ===== hw/rtl/wut_ram.sv =====
// ----------------------------------------------------------------------------
// wut_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wut_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 63
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         re,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/wut_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// wut_cmd_fifo
// Short queue of report requests between the classifier and the reader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wut_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  wut_pkg::cmd_t       push_cmd,
  input  logic                pop,
  output wut_pkg::cmd_t       head_cmd,
  output wut_pkg::fifo_stat_t stat
);
  import wut_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          mem_r [CMD_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd     = mem_r[rd_ptr_r];
  assign stat.full    = (count_r == CW'(CMD_DEPTH));
  assign stat.pending = (count_r != '0);

endmodule

// ===== hw/rtl/wut_front.sv =====
// ----------------------------------------------------------------------------
// wut_front
// Classifier: runs the tokenizer rules, keeps the word buffer, queues reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wut_front #(
  parameter int MAX_WORD_CHARS = 63
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wut_pkg::CHAR_W-1:0]    char_code,
  input  logic                          end_of_input,
  input  wut_pkg::fifo_stat_t           fifo_stat,
  output logic                          push,
  output wut_pkg::cmd_t                 push_cmd,
  output logic                          we,
  output logic [$clog2(MAX_WORD_CHARS)-1:0] waddr,
  output logic [wut_pkg::CHAR_W-1:0]    wdata
);
  import wut_pkg::*;

  localparam int AW = $clog2(MAX_WORD_CHARS);

  typedef enum logic [1:0] {ACT_NONE, ACT_COLLECT, ACT_PRINT} act_t;
  typedef enum logic [1:0] {OP_NONE, OP_APPEND, OP_RESTART, OP_CLEAR} op_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    is_space = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic logic is_print(input logic [CHAR_W-1:0] c);
    is_print = (c >= CH_SPACE && c <= CH_TILDE) || c > CH_DEL;
  endfunction

  function automatic logic is_graph(input logic [CHAR_W-1:0] c);
    is_graph = (c >= CH_BANG && c <= CH_TILDE) || c > CH_DEL;
  endfunction

  function automatic logic is_cntrl(input logic [CHAR_W-1:0] c);
    is_cntrl = c <= CH_US || c == CH_DEL;
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    is_alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic logic is_scheme(input logic [CHAR_W-1:0] c);
    is_scheme = is_alpha(c) || (c >= CH_DIG_0 && c <= CH_DIG_9) ||
                c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
  endfunction

  function automatic logic is_quote(input logic [CHAR_W-1:0] c);
    is_quote = c == CH_SQUOTE || c == CH_DQUOTE;
  endfunction

  state_t            st_r, st_nxt, tgt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CHAR_W-1:0] first_r, first_nxt;
  logic              match, sw;
  act_t              act;
  op_t               op;
  logic              accept;
  logic              push_req, we_req;

  // rule selection: first matching class rule of the current state
  always_comb begin
    match = 1'b1;
    sw    = 1'b0;
    act   = ACT_NONE;
    tgt   = st_r;
    case (st_r)
      ST_GROUND: begin
        if (is_space(char_code)) begin
        end else if (is_quote(char_code)) begin
          sw = 1'b1; tgt = ST_QUOTED;
        end else if (is_alpha(char_code)) begin
          sw = 1'b1; tgt = ST_URI_MAYBE;
        end else if (is_print(char_code)) begin
          sw = 1'b1; tgt = ST_WORD;
        end else begin
          match = 1'b0;
        end
      end
      ST_WORD: begin
        if (char_code == CH_COLON || char_code == CH_PIPE || is_space(char_code)) begin
          act = ACT_PRINT; sw = 1'b1; tgt = ST_GROUND;
        end else if (is_graph(char_code)) begin
          act = ACT_COLLECT;
        end else begin
          match = 1'b0;
        end
      end
      ST_QUOTED: begin
        if (is_quote(char_code)) begin
          sw = 1'b1; tgt = ST_WORD;
        end else if (is_print(char_code)) begin
          act = ACT_COLLECT;
        end else if (is_cntrl(char_code)) begin
          sw = 1'b1; tgt = ST_GROUND;
        end else begin
          match = 1'b0;
        end
      end
      ST_URI_MAYBE: begin
        if (char_code == CH_COLON) begin
          act = ACT_PRINT; sw = 1'b1; tgt = ST_END_SCHEME;
        end else if (is_scheme(char_code)) begin
          act = ACT_COLLECT;
        end else if (char_code == CH_PIPE || is_space(char_code)) begin
          act = ACT_PRINT; sw = 1'b1; tgt = ST_GROUND;
        end else if (is_graph(char_code)) begin
          sw = 1'b1; tgt = ST_WORD;
        end else begin
          match = 1'b0;
        end
      end
      ST_END_SCHEME: begin
        if (char_code == CH_SLASH) begin
          sw = 1'b1; tgt = ST_POST_SCHEME;
        end else if (is_graph(char_code)) begin
          sw = 1'b1; tgt = ST_PATH;
        end else if (is_space(char_code)) begin
          sw = 1'b1; tgt = ST_GROUND;
        end else begin
          match = 1'b0;
        end
      end
      ST_POST_SCHEME: begin
        if (char_code == CH_SLASH) begin
          sw = 1'b1; tgt = ST_AUTH;
        end else if (is_graph(char_code)) begin
          sw = 1'b1; tgt = ST_PATH;
        end else if (is_space(char_code)) begin
          act = ACT_PRINT; sw = 1'b1; tgt = ST_GROUND;
        end else begin
          match = 1'b0;
        end
      end
      ST_AUTH: begin
        if (char_code == CH_SLASH) begin
          act = ACT_PRINT; sw = 1'b1; tgt = ST_PATH;
        end else if (is_graph(char_code)) begin
          act = ACT_COLLECT;
        end else if (is_space(char_code)) begin
          act = ACT_PRINT; sw = 1'b1; tgt = ST_GROUND;
        end else begin
          match = 1'b0;
        end
      end
      ST_PATH: begin
        if (is_graph(char_code)) begin
          act = ACT_COLLECT;
        end else if (is_space(char_code)) begin
          act = ACT_PRINT; sw = 1'b1; tgt = ST_GROUND;
        end else begin
          match = 1'b0;
        end
      end
      default: begin
        match = 1'b0;
      end
    endcase
  end

  // next parse state
  always_comb begin
    if (end_of_input || !match) begin
      st_nxt = ST_GROUND;
    end else if (sw) begin
      st_nxt = tgt;
    end else begin
      st_nxt = st_r;
    end
  end

  // word operation, report request and buffer write
  always_comb begin
    op            = OP_NONE;
    push_req      = 1'b0;
    push_cmd.kind = KIND_WORD;
    push_cmd.len  = len_r;
    push_cmd.ovf  = ovf_r;
    push_cmd.ch   = first_r;
    if (end_of_input) begin
      push_req      = 1'b1;
      push_cmd.kind = KIND_PEND;
      op            = OP_CLEAR;
    end else if (!match) begin
      push_req      = 1'b1;
      push_cmd.kind = KIND_ERR;
      push_cmd.ch   = char_code;
      op            = OP_CLEAR;
    end else begin
      push_req = (act == ACT_PRINT);
      if (act == ACT_COLLECT) begin
        op = OP_APPEND;
      end else if (sw) begin
        case (tgt)
          ST_GROUND, ST_AUTH: op = OP_CLEAR;
          ST_QUOTED, ST_PATH: op = OP_RESTART;
          default:            op = OP_APPEND;
        endcase
      end
    end

    we_req    = 1'b0;
    waddr     = len_r[AW-1:0];
    wdata     = char_code;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    first_nxt = first_r;
    case (op)
      OP_APPEND: begin
        if (len_r < LEN_W'(MAX_WORD_CHARS)) begin
          we_req  = 1'b1;
          len_nxt = len_r + LEN_W'(1);
          if (len_r == '0) begin
            first_nxt = char_code;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      OP_RESTART: begin
        we_req    = 1'b1;
        waddr     = '0;
        len_nxt   = LEN_W'(1);
        ovf_nxt   = 1'b0;
        first_nxt = char_code;
      end
      OP_CLEAR: begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // hold a report on a full queue and a buffer write while reports are queued
  assign in_ready = !(push_req && fifo_stat.full) && !(we_req && fifo_stat.pending);
  assign accept   = in_valid && in_ready;
  assign push     = push_req && accept;
  assign we       = we_req && accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_GROUND;
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_nxt;
    end
  end

endmodule

// ===== hw/rtl/wut_back.sv =====
// ----------------------------------------------------------------------------
// wut_back
// Report reader: walks queued words through the buffer, one character per
// result, into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wut_back #(
  parameter int MAX_WORD_CHARS = 63
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wut_pkg::fifo_stat_t               fifo_stat,
  input  wut_pkg::cmd_t                     head_cmd,
  output logic                              pop,
  output logic                              re,
  output logic [$clog2(MAX_WORD_CHARS)-1:0] raddr,
  input  logic [wut_pkg::CHAR_W-1:0]        rdata,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wut_pkg::kind_t                    out_kind,
  output logic [wut_pkg::CHAR_W-1:0]        out_char,
  output logic                              out_last,
  output logic                              out_empty,
  output logic                              out_trunc
);
  import wut_pkg::*;

  localparam int AW = $clog2(MAX_WORD_CHARS);

  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  kind_t             s1_kind_r;
  logic              s1_last_r, s1_empty_r, s1_trunc_r, s1_use_ram_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              o_valid_r, o_valid_nxt;
  kind_t             o_kind_r;
  logic              o_last_r, o_empty_r, o_trunc_r;
  logic [CHAR_W-1:0] o_char_r;

  logic s2_load, s1_free, issue, single, is_err, last_i, use_ram;

  assign s2_load = s1_valid_r && (!o_valid_r || out_ready);
  assign s1_free = !s1_valid_r || s2_load;
  assign issue   = fifo_stat.pending && s1_free;
  assign is_err  = (head_cmd.kind == KIND_ERR);
  assign single  = is_err || (head_cmd.len == '0);
  assign last_i  = single || (idx_r == head_cmd.len - LEN_W'(1));
  // the first character comes with the request, the rest from the buffer
  assign use_ram = !single && (idx_r != '0);
  assign pop     = issue && last_i;
  assign re      = issue && use_ram;
  assign raddr   = idx_r[AW-1:0];

  always_comb begin
    idx_nxt = idx_r;
    if (issue) begin
      idx_nxt = last_i ? '0 : idx_r + LEN_W'(1);
    end
    s1_valid_nxt = issue || (s1_valid_r && !s2_load);
    o_valid_nxt  = s2_load || (o_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      idx_r      <= idx_nxt;
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r    <= head_cmd.kind;
      s1_last_r    <= last_i;
      s1_empty_r   <= !is_err && (head_cmd.len == '0);
      s1_trunc_r   <= !is_err && head_cmd.ovf;
      s1_use_ram_r <= use_ram;
      s1_char_r    <= (!is_err && head_cmd.len == '0) ? '0 : head_cmd.ch;
    end
    if (s2_load) begin
      o_kind_r  <= s1_kind_r;
      o_last_r  <= s1_last_r;
      o_empty_r <= s1_empty_r;
      o_trunc_r <= s1_trunc_r;
      o_char_r  <= s1_use_ram_r ? rdata : s1_char_r;
    end
  end

  assign out_valid = o_valid_r;
  assign out_kind  = o_kind_r;
  assign out_char  = o_char_r;
  assign out_last  = o_last_r;
  assign out_empty = o_empty_r;
  assign out_trunc = o_trunc_r;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream-level test of the word and URI tokenizer core.
// ----------------------------------------------------------------------------
// Character requests go in through the input stream. A scoreboard class
// replays the tokenizer rules on every accepted request and queues the word
// reports it should cause, one entry per character. The queue is then matched
// against the output stream. A short directed sequence comes first. Random
// words, quoted words, URIs, noise codes, end-of-input flushes and over-long
// words follow, under four idling patterns. One long output stall fills the
// report queue and backs up the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wut_pkg::*;

  localparam int WORD_MAX = 63;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [CHAR_W-1:0] CH_HIGH = 21'd128;
  localparam logic [CHAR_W-1:0] CH_TOP = 21'h1FFFFF;

  typedef enum {ACT_NONE, ACT_COLLECT, ACT_PRINT} act_t;

  typedef struct {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    bit                last;
    bit                empty;
    bit                trunc;
  } report_t;

  class tokenizer_scoreboard;
    state_t            st;
    logic [CHAR_W-1:0] word_buf [WORD_MAX];
    int unsigned       len;
    bit                ovf;
    act_t              r_act;
    bit                r_sw;
    state_t            r_next;
    report_t           report_q[$];
    int                mismatches;

    function new();
      st = ST_GROUND;
      len = 0;
      ovf = 1'b0;
      mismatches = 0;
    endfunction

    function bit is_space(logic [CHAR_W-1:0] c);
      return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction
    function bit is_print(logic [CHAR_W-1:0] c);
      return (c >= CH_SPACE && c <= CH_TILDE) || c >= CH_HIGH;
    endfunction
    function bit is_graph(logic [CHAR_W-1:0] c);
      return (c >= CH_BANG && c <= CH_TILDE) || c >= CH_HIGH;
    endfunction
    function bit is_cntrl(logic [CHAR_W-1:0] c);
      return c <= CH_US || c == CH_DEL;
    endfunction
    function bit is_alpha(logic [CHAR_W-1:0] c);
      return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction
    function bit is_alnum(logic [CHAR_W-1:0] c);
      return is_alpha(c) || (c >= CH_DIG_0 && c <= CH_DIG_9);
    endfunction
    function bit is_quote(logic [CHAR_W-1:0] c);
      return c == CH_SQUOTE || c == CH_DQUOTE;
    endfunction
    function bit is_scheme(logic [CHAR_W-1:0] c);
      return is_alnum(c) || c == CH_PLUS || c == CH_MINUS || c == CH_DOT;
    endfunction

    function void clear();
      len = 0;
      ovf = 1'b0;
    endfunction

    // drop the character and flag overflow once the buffer is full
    function void append(logic [CHAR_W-1:0] c);
      if (len < WORD_MAX) begin
        word_buf[len] = c;
        len++;
      end else begin
        ovf = 1'b1;
      end
    endfunction

    function void queue_word(kind_t k);
      report_t r;
      if (len == 0) begin
        r = '{kind: k, ch: '0, last: 1'b1, empty: 1'b1, trunc: ovf};
        report_q.push_back(r);
      end else begin
        for (int unsigned i = 0; i < len; i++) begin
          r = '{kind: k, ch: word_buf[i], last: (i + 1 == len), empty: 1'b0, trunc: ovf};
          report_q.push_back(r);
        end
      end
    endfunction

    function bit take(act_t a, bit sw, state_t n);
      r_act = a;
      r_sw = sw;
      r_next = n;
      return 1'b1;
    endfunction

    // first matching rule of the current state; 0 when none matches
    function bit pick_rule(logic [CHAR_W-1:0] c);
      case (st)
        ST_GROUND: begin
          if (is_space(c)) return take(ACT_NONE, 1'b0, ST_GROUND);
          if (is_quote(c)) return take(ACT_NONE, 1'b1, ST_QUOTED);
          if (is_alpha(c)) return take(ACT_NONE, 1'b1, ST_URI_MAYBE);
          if (is_print(c)) return take(ACT_NONE, 1'b1, ST_WORD);
        end
        ST_WORD: begin
          if (c == CH_COLON || c == CH_PIPE || is_space(c))
            return take(ACT_PRINT, 1'b1, ST_GROUND);
          if (is_graph(c)) return take(ACT_COLLECT, 1'b0, ST_WORD);
        end
        ST_QUOTED: begin
          if (is_quote(c)) return take(ACT_NONE, 1'b1, ST_WORD);
          if (is_print(c)) return take(ACT_COLLECT, 1'b0, ST_QUOTED);
          if (is_cntrl(c)) return take(ACT_NONE, 1'b1, ST_GROUND);
        end
        ST_URI_MAYBE: begin
          if (c == CH_COLON) return take(ACT_PRINT, 1'b1, ST_END_SCHEME);
          if (is_scheme(c)) return take(ACT_COLLECT, 1'b0, ST_URI_MAYBE);
          if (c == CH_PIPE || is_space(c)) return take(ACT_PRINT, 1'b1, ST_GROUND);
          if (is_graph(c)) return take(ACT_NONE, 1'b1, ST_WORD);
        end
        ST_END_SCHEME: begin
          if (c == CH_SLASH) return take(ACT_NONE, 1'b1, ST_POST_SCHEME);
          if (is_graph(c)) return take(ACT_NONE, 1'b1, ST_PATH);
          if (is_space(c)) return take(ACT_NONE, 1'b1, ST_GROUND);
        end
        ST_POST_SCHEME: begin
          if (c == CH_SLASH) return take(ACT_NONE, 1'b1, ST_AUTH);
          if (is_graph(c)) return take(ACT_NONE, 1'b1, ST_PATH);
          if (is_space(c)) return take(ACT_PRINT, 1'b1, ST_GROUND);
        end
        ST_AUTH: begin
          if (c == CH_SLASH) return take(ACT_PRINT, 1'b1, ST_PATH);
          if (is_graph(c)) return take(ACT_COLLECT, 1'b0, ST_AUTH);
          if (is_space(c)) return take(ACT_PRINT, 1'b1, ST_GROUND);
        end
        default: begin
          if (is_graph(c)) return take(ACT_COLLECT, 1'b0, ST_PATH);
          if (is_space(c)) return take(ACT_PRINT, 1'b1, ST_GROUND);
        end
      endcase
      return 1'b0;
    endfunction

    function void enter(state_t n, logic [CHAR_W-1:0] c);
      st = n;
      case (n)
        ST_GROUND, ST_AUTH: clear();
        ST_QUOTED, ST_PATH: begin
          clear();
          append(c);
        end
        default: append(c);
      endcase
    endfunction

    function void feed_char(logic [CHAR_W-1:0] c, bit eoi);
      report_t r;
      if (eoi) begin
        queue_word(KIND_PEND);
        st = ST_GROUND;
        clear();
        return;
      end
      if (!pick_rule(c)) begin
        r = '{kind: KIND_ERR, ch: c, last: 1'b1, empty: 1'b0, trunc: 1'b0};
        report_q.push_back(r);
        st = ST_GROUND;
        clear();
        return;
      end
      if (r_act == ACT_COLLECT) append(c);
      else if (r_act == ACT_PRINT) queue_word(KIND_WORD);
      if (r_sw) enter(r_next, c);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task match_result(logic [1:0] kind, logic [CHAR_W-1:0] ch, logic last,
                      logic empty, logic trunc);
      report_t r;
      if (report_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d char %0h", kind, ch));
        return;
      end
      r = report_q.pop_front();
      if (kind !== r.kind || ch !== r.ch || last !== r.last || empty !== r.empty ||
          trunc !== r.trunc)
        report_mismatch($sformatf(
          "kind %0d/%0d char %0h/%0h last %0b/%0b empty %0b/%0b trunc %0b/%0b",
          kind, r.kind, ch, r.ch, last, r.last, empty, r.empty, trunc, r.trunc));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int send_pct = 0;
  int recv_pct = 0;
  int hold_left = 0;
  int sent = 0;

  tokenizer_scoreboard sb = new();

  word_and_uri_tokenizer_core #(
    .MAX_WORD_CHARS(WORD_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: long hold-off first when requested, else random stalls
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(0, 99) >= recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.match_result(out_tuser, out_tdata[20:0], out_tlast, out_tdata[21], out_tdata[22]);
  end

  function automatic logic [CHAR_W-1:0] rand_alpha();
    return $urandom_range(0, 1) ? CHAR_W'($urandom_range(CH_UP_A, CH_UP_Z))
                                : CHAR_W'($urandom_range(CH_LO_A, CH_LO_Z));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_graph();
    return CHAR_W'($urandom_range(CH_BANG, CH_TILDE));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_word_char();
    case ($urandom_range(0, 3))
      0: return CHAR_W'($urandom_range(CH_DIG_0, CH_DIG_9));
      1: return rand_graph();
      default: return rand_alpha();
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_scheme();
    case ($urandom_range(0, 5))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_DOT;
      3: return CHAR_W'($urandom_range(CH_DIG_0, CH_DIG_9));
      default: return rand_alpha();
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_space();
    return $urandom_range(0, 2) ? CH_SPACE : CHAR_W'($urandom_range(CH_TAB, CH_CR));
  endfunction

  function automatic logic [CHAR_W-1:0] rand_sep();
    case ($urandom_range(0, 3))
      0: return CH_PIPE;
      1: return CH_COLON;
      default: return rand_space();
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] rand_code();
    return $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, CH_TOP))
                                : CHAR_W'($urandom_range(0, CH_DEL));
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input logic [CHAR_W-1:0] c, input bit eoi);
    while ($urandom_range(0, 99) < send_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {3'b000, c};
    in_tlast = eoi;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.feed_char(c, eoi);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(CHAR_W'(s[i]), 1'b0);
  endtask

  task automatic send_long_word(input int min_len);
    int n;
    n = $urandom_range(min_len, 70);
    repeat (n) send(rand_word_char(), 1'b0);
    send(rand_space(), 1'b0);
  endtask

  task automatic send_uri();
    int n;
    send(rand_alpha(), 1'b0);
    n = $urandom_range(0, 4);
    repeat (n) send(rand_scheme(), 1'b0);
    send(CH_COLON, 1'b0);
    case ($urandom_range(0, 3))
      0: begin
        send(CH_SLASH, 1'b0);
        send(CH_SLASH, 1'b0);
        n = $urandom_range(0, 6);
        repeat (n) send(rand_alpha(), 1'b0);
        if ($urandom_range(0, 1)) begin
          send(CH_SLASH, 1'b0);
          n = $urandom_range(0, 5);
          repeat (n) send(rand_graph(), 1'b0);
        end
      end
      1: begin
        send(CH_SLASH, 1'b0);
        n = $urandom_range(0, 4);
        repeat (n) send(rand_graph(), 1'b0);
      end
      2: begin
        n = $urandom_range(1, 5);
        repeat (n) send(rand_graph(), 1'b0);
      end
      default: ;
    endcase
    send(rand_space(), 1'b0);
  endtask

  task automatic send_segment();
    int pick;
    int n;
    logic [CHAR_W-1:0] q;
    pick = $urandom_range(0, 99);
    n = $urandom_range(0, 6);
    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
    if (pick < 25) begin
      repeat (n + 1) send(rand_word_char(), 1'b0);
      send(rand_sep(), 1'b0);
    end else if (pick < 40) begin
      send(q, 1'b0);
      repeat (n) send(CHAR_W'($urandom_range(CH_SPACE, CH_TILDE)), 1'b0);
      // a control code inside quotes drops back to ground
      if ($urandom_range(0, 3) == 0) begin
        send(CHAR_W'($urandom_range(0, CH_US)), 1'b0);
      end else begin
        send(q, 1'b0);
        send(rand_sep(), 1'b0);
      end
    end else if (pick < 65) begin
      send_uri();
    end else if (pick < 75) begin
      repeat ((n % 3) + 1) send(rand_code(), 1'b0);
    end else if (pick < 85) begin
      repeat (n % 4) send(rand_word_char(), 1'b0);
      send(rand_code(), 1'b1);
    end else if (pick < 95) begin
      repeat ((n % 5) + 1) send(CHAR_W'($urandom_range(CH_HIGH, CH_TOP)), 1'b0);
      send(rand_sep(), 1'b0);
    end else begin
      send_long_word(60);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty flush, control and top codes, quotes, URI, pending flush
    send(CH_TOP, 1'b1);
    send('0, 1'b0);
    send(CH_TOP, 1'b0);
    send(CH_SPACE, 1'b0);
    send_text("x");
    send(CH_DEL, 1'b0);
    send_text("\"a b\"|");
    send_text("h:///p\t");
    send(CH_SQUOTE, 1'b0);
    send(21'd1, 1'b0);
    send_text("9");
    send(CHAR_W'($urandom_range(0, CH_TOP)), 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_pct = 0;
          recv_pct = 0;
          // hold the output long enough to fill the report queue
          hold_left = 400;
          send_long_word(64);
        end
        1: begin
          send_pct = 76;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 76;
        end
        default: begin
          send_pct = 33;
          recv_pct = 33;
        end
      endcase
      sent = 0;
      while (sent < 6) send_segment();
    end

    in_tvalid = 1'b0;
    in_tlast = 1'b0;
    recv_pct = 0;
    while (sb.report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.report_q.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb_top: errors");
    $finish;
  end

endmodule
